FILE: hdl/tlg_pkg.sv
// Shared types and constants of the toroidal Life generation engine.
package tlg_pkg;

	// Item opcodes.
	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_WRITE = 2'd0;
	localparam opcode_t OP_STEP  = 2'd1;
	localparam opcode_t OP_READ  = 2'd2;

	// Configuration register indexes.
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t CFG_ROWS = 1'd0;
	localparam cfg_index_t CFG_COLS = 1'd1;

	// Field and register widths.
	localparam int ROW_IDX_W = 5;
	localparam int COL_IDX_W = 7;
	localparam int ROWS_REG_W = 6;
	localparam int COLS_REG_W = 8;
	localparam int CFG_DATA_W = 8;

	// Register reset values and the smallest usable grid size.
	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd25;
	localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
	localparam int MIN_SIZE = 3;

	// Rule B3/S23 neighbor counts.
	localparam logic [3:0] LIVE_BIRTH = 4'd3;
	localparam logic [3:0] LIVE_KEEP  = 4'd2;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_PRE0,
		S_PRE1,
		S_PRE2,
		S_ROW,
		S_DONE
	} tlg_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic req_ready;
		logic wr_cell;
		logic rd_cell;
		logic rd_last;
		logic rd_first;
		logic rd_second;
		logic row_go;
		logic load_rsp;
	} tlg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic    req_valid;
		opcode_t req_op;
		logic    last_row;
		logic    rsp_free;
	} tlg_status_t;

endpackage

FILE: hdl/tlg_ifs.sv
// Channel interfaces of the toroidal Life generation engine.
interface tlg_req_if;
	logic                          valid;
	logic                          ready;
	tlg_pkg::opcode_t              opcode;
	logic [tlg_pkg::ROW_IDX_W-1:0] row_index;
	logic [tlg_pkg::COL_IDX_W-1:0] col_index;
	logic                          cell_in;

	modport source (output valid, opcode, row_index, col_index, cell_in, input ready);
	modport sink (input valid, opcode, row_index, col_index, cell_in, output ready);
endinterface

interface tlg_rsp_if;
	logic             valid;
	logic             ready;
	logic             cell_out;
	tlg_pkg::opcode_t done_opcode;

	modport source (output valid, cell_out, done_opcode, input ready);
	modport sink (input valid, cell_out, done_opcode, output ready);
endinterface

interface tlg_cfg_if;
	logic                           valid;
	logic                           ready;
	tlg_pkg::cfg_index_t            index;
	logic [tlg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/tlg_ctrl.sv
// Controller state machine that sequences cell accesses and generation steps.
module tlg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlg_pkg::tlg_status_t status,
	output tlg_pkg::tlg_cmd_t    cmd
);
	import tlg_pkg::*;

	tlg_state_t state_q;
	tlg_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (status.req_valid) begin
					case (status.req_op)
						OP_WRITE: state_nxt = S_WRITE;
						OP_STEP:  state_nxt = S_PRE0;
						OP_READ:  state_nxt = S_READ;
						default:  state_nxt = S_DONE;
					endcase
				end
			end
			S_WRITE: state_nxt = S_DONE;
			S_READ:  state_nxt = S_DONE;
			S_PRE0:  state_nxt = S_PRE1;
			S_PRE1:  state_nxt = S_PRE2;
			S_PRE2:  state_nxt = S_ROW;
			S_ROW: begin
				if (status.last_row) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (status.rsp_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:  cmd.req_ready = 1'b1;
			S_WRITE: cmd.wr_cell = 1'b1;
			S_READ:  cmd.rd_cell = 1'b1;
			S_PRE0:  cmd.rd_last = 1'b1;
			S_PRE1:  cmd.rd_first = 1'b1;
			S_PRE2:  cmd.rd_second = 1'b1;
			S_ROW:   cmd.row_go = 1'b1;
			S_DONE:  cmd.load_rsp = status.rsp_free;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: hdl/tlg_datapath.sv
// Datapath: grid memory, row window, neighbor logic, registers and result stage.
module tlg_datapath #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlg_pkg::tlg_cmd_t    cmd,
	output tlg_pkg::tlg_status_t status,
	tlg_req_if.sink              req,
	tlg_rsp_if.source            rsp,
	tlg_cfg_if.sink              cfg
);
	import tlg_pkg::*;

	localparam int RAW = $clog2(MAX_ROWS);
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int RPW = RCW + 1;
	localparam int CIW = $clog2(MAX_COLS);
	localparam int CCW = $clog2(MAX_COLS + 1);

	// Configuration registers.
	logic [ROWS_REG_W-1:0] rows_q;
	logic [COLS_REG_W-1:0] cols_q;

	// Captured item.
	opcode_t              op_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic [COL_IDX_W-1:0] col_q;
	logic                 cell_q;

	// Grid storage and its read port.
	logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_vld_q;
	logic [MAX_COLS-1:0] rdata_q;
	logic                rvld_q;
	logic [MAX_COLS-1:0] rdata_eff;
	logic                rd_en;
	logic [RAW-1:0]      rd_addr;
	logic                mem_we;
	logic [RAW-1:0]      waddr;
	logic [MAX_COLS-1:0] wdata;
	logic [MAX_COLS-1:0] wmask;

	// Row window for a generation step.
	logic [MAX_COLS-1:0] prev_q;
	logic [MAX_COLS-1:0] cur_q;
	logic [MAX_COLS-1:0] row0_q;
	logic [MAX_COLS-1:0] nxt_row;
	logic [MAX_COLS-1:0] new_row;
	logic [RAW-1:0]      r_q;
	logic [RPW-1:0]      r_plus2;

	// Effective sizes and helpers.
	logic [RCW-1:0]      n_rows;
	logic [CCW-1:0]      n_cols;
	logic [CIW-1:0]      col_last;
	logic                in_grid;
	logic [MAX_COLS-1:0] cell_onehot;
	logic                last_row;

	// Result stage.
	logic    rsp_valid_q;
	logic    cell_out_q;
	opcode_t done_opcode_q;

	// Clamp the size registers into the legal range.
	always_comb begin
		if (rows_q < ROWS_REG_W'(MIN_SIZE)) begin
			n_rows = RCW'(MIN_SIZE);
		end else if (int'(rows_q) > MAX_ROWS) begin
			n_rows = RCW'(MAX_ROWS);
		end else begin
			n_rows = RCW'(rows_q);
		end
		if (cols_q < COLS_REG_W'(MIN_SIZE)) begin
			n_cols = CCW'(MIN_SIZE);
		end else if (int'(cols_q) > MAX_COLS) begin
			n_cols = CCW'(MAX_COLS);
		end else begin
			n_cols = CCW'(cols_q);
		end
	end

	assign col_last = CIW'(n_cols - CCW'(1));
	assign last_row = (RCW'(r_q) == (n_rows - RCW'(1)));
	assign r_plus2 = RPW'(r_q) + RPW'(2);
	assign in_grid = (int'(row_q) < MAX_ROWS) && (int'(col_q) < MAX_COLS);
	assign cell_onehot = MAX_COLS'(1) << CIW'(col_q);

	// Status toward the controller.
	assign status.req_valid = req.valid;
	assign status.req_op = req.opcode;
	assign status.last_row = last_row;
	assign status.rsp_free = !rsp_valid_q || rsp.ready;

	assign req.ready = cmd.req_ready;
	assign cfg.ready = 1'b1;

	// Configuration writes; an index beyond the list changes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ROWS: rows_q <= cfg.data[ROWS_REG_W-1:0];
				CFG_COLS: cols_q <= cfg.data[COLS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the item on each input transaction.
	always_ff @(posedge clk) begin
		if (req.valid && cmd.req_ready) begin
			op_q   <= req.opcode;
			row_q  <= req.row_index;
			col_q  <= req.col_index;
			cell_q <= req.cell_in;
		end
	end

	// Read address selection.
	always_comb begin
		rd_en = 1'b1;
		rd_addr = '0;
		if (cmd.rd_cell) begin
			rd_addr = RAW'(row_q);
		end else if (cmd.rd_last) begin
			rd_addr = RAW'(n_rows - RCW'(1));
		end else if (cmd.rd_first) begin
			rd_addr = '0;
		end else if (cmd.rd_second) begin
			rd_addr = RAW'(1);
		end else if (cmd.row_go) begin
			if (r_plus2 < RPW'(n_rows)) begin
				rd_addr = RAW'(r_plus2);
			end
		end else begin
			rd_en = 1'b0;
		end
	end

	// Write port: a whole new row during a step, or a single cell.
	// A row never written before is filled with dead cells around the new one.
	always_comb begin
		mem_we = 1'b0;
		waddr = r_q;
		wdata = new_row;
		wmask = '1;
		if (cmd.row_go) begin
			mem_we = 1'b1;
		end else if (cmd.wr_cell && in_grid) begin
			mem_we = 1'b1;
			waddr = RAW'(row_q);
			wdata = cell_q ? cell_onehot : '0;
			wmask = row_vld_q[RAW'(row_q)] ? cell_onehot : '1;
		end
	end

	// Grid memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int i = 0; i < MAX_COLS; i++) begin
				if (wmask[i]) begin
					grid_mem[waddr][i] <= wdata[i];
				end
			end
		end
		if (rd_en) begin
			rdata_q <= grid_mem[rd_addr];
			rvld_q  <= row_vld_q[rd_addr];
		end
	end

	// Row valid bits: a row reads as all dead until first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (mem_we) begin
			row_vld_q[waddr] <= 1'b1;
		end
	end

	assign rdata_eff = rvld_q ? rdata_q : '0;

	// The row below wraps to the saved copy of row 0 on the last row.
	assign nxt_row = last_row ? row0_q : rdata_eff;

	// Row window and row counter.
	always_ff @(posedge clk) begin
		if (cmd.rd_first) begin
			prev_q <= rdata_eff;
		end
		if (cmd.rd_second) begin
			cur_q  <= rdata_eff;
			row0_q <= rdata_eff;
			r_q    <= '0;
		end
		if (cmd.row_go) begin
			prev_q <= cur_q;
			cur_q  <= nxt_row;
			r_q    <= r_q + RAW'(1);
		end
	end

	// B3/S23 rule on each column in use of the current row, wrapping at col_last; columns beyond keep their cells.
	always_comb begin
		logic [3:0] cnt;
		logic       pl;
		logic       pr;
		logic       cl;
		logic       cr;
		logic       nl;
		logic       nr;
		for (int c = 0; c < MAX_COLS; c++) begin
			if (c == 0) begin
				pl = prev_q[col_last];
				cl = cur_q[col_last];
				nl = nxt_row[col_last];
			end else begin
				pl = prev_q[c-1];
				cl = cur_q[c-1];
				nl = nxt_row[c-1];
			end
			if (CIW'(c) == col_last || c == MAX_COLS - 1) begin
				pr = prev_q[0];
				cr = cur_q[0];
				nr = nxt_row[0];
			end else begin
				pr = prev_q[c+1];
				cr = cur_q[c+1];
				nr = nxt_row[c+1];
			end
			cnt = {3'b0, pl} + {3'b0, prev_q[c]} + {3'b0, pr} + {3'b0, cl} + {3'b0, cr}
				+ {3'b0, nl} + {3'b0, nxt_row[c]} + {3'b0, nr};
			if (c < int'(n_cols)) begin
				new_row[c] = (cnt == LIVE_BIRTH) || ((cnt == LIVE_KEEP) && cur_q[c]);
			end else begin
				new_row[c] = cur_q[c];
			end
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			cell_out_q    <= (op_q == OP_READ) && in_grid && rdata_eff[CIW'(col_q)];
			done_opcode_q <= op_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.cell_out = cell_out_q;
	assign rsp.done_opcode = done_opcode_q;

endmodule

FILE: hdl/toroidal_life_generation_engine_core.sv
// Top level of the toroidal Life generation engine.
//
//   channel | dir | payload                                  | transaction when
//   --------+-----+------------------------------------------+------------------
//   req     | in  | opcode, row_index, col_index, cell_in    | valid && ready
//   rsp     | out | cell_out, done_opcode                    | valid && ready
//   cfg     | in  | index (0 rows_in_use, 1 cols_in_use), data | valid && ready
//
// One item at a time: a write or read runs through its state and S_DONE, an unused
// opcode through S_DONE alone, and a step through S_PRE0, S_PRE1, S_PRE2 (the window
// preload) and S_ROW, where the single read port delivers one row per cycle.
// Reset leaves the grid all dead through per-row valid bits; no clearing.
// While a result waits on rsp, the next item is accepted and finishes up to
// its result, which then waits for the output register to free up.
module toroidal_life_generation_engine_core #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128
) (
	input logic       clk,
	input logic       arst_n,
	tlg_req_if.sink   req,
	tlg_rsp_if.source rsp,
	tlg_cfg_if.sink   cfg
);
	import tlg_pkg::*;

	tlg_cmd_t    cmd;
	tlg_status_t status;

	// Sequencer.
	tlg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Grid storage and generation logic.
	tlg_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule

FILE: hdl/tlg_checker.sv
// Port-level checker of the toroidal Life generation engine and its binding.
module tlg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input tlg_pkg::opcode_t req_opcode,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             rsp_cell_out,
	input tlg_pkg::opcode_t rsp_done_opcode
);
	import tlg_pkg::*;

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("input accepted again right after a transaction");

	// A step item keeps the input closed for at least the window preload.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode == OP_STEP |=> ##3 !req_ready)
	else $error("step finished faster than the row window allows");

	// Only a read can report a live cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_done_opcode != OP_READ |-> !rsp_cell_out)
	else $error("live cell reported for an item that is not a read");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_out)
			&& $stable(rsp_done_opcode))
	else $error("result changed while stalled");

endmodule

bind toroidal_life_generation_engine_core tlg_checker u_tlg_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_opcode      (req.opcode),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_cell_out    (rsp.cell_out),
	.rsp_done_opcode (rsp.done_opcode)
);

FILE: tb/toroidal_life_generation_engine_core_test.sv
// Self-checking testbench for the toroidal Life generation engine core.
`timescale 1ns / 100ps

module toroidal_life_generation_engine_core_test;
	import tlg_pkg::*;

	localparam int GRID_ROWS = 32;
	localparam int GRID_COLS = 128;
	localparam int MAX_GAP = 7;
	localparam int DRAIN_CYCLES = 5 + GRID_ROWS + 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_PRINTED_ERRORS = 50;

	// The opcode that the package leaves unnamed; the block must echo it.
	localparam opcode_t OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	tlg_req_if req_ch ();
	tlg_rsp_if rsp_ch ();
	tlg_cfg_if cfg_ch ();

	toroidal_life_generation_engine_core #(
		.MAX_ROWS(GRID_ROWS),
		.MAX_COLS(GRID_COLS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Predictor state: the cell grid and the two size registers.
	bit [GRID_COLS-1:0]    life_grid [GRID_ROWS];
	logic [ROWS_REG_W-1:0] rows_reg = ROWS_RESET;
	logic [COLS_REG_W-1:0] cols_reg = COLS_RESET;

	// Expected results, oldest first.
	logic    expected_cell_out [$];
	opcode_t expected_done_op [$];

	// Run control and bookkeeping.
	bit sender_idle_on = 1'b1;
	bit receiver_idle_on = 1'b1;
	int hold_cycles = 0;
	int error_count = 0;
	int results_checked = 0;
	int items_sent = 0;
	int settings_written = 0;
	int cycle_count = 0;
	int op_count [4];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Size clamping of a register value to the usable range.
	function automatic int clamp_grid_size(int value, int max_size);
		if (value < MIN_SIZE)
			return MIN_SIZE;
		if (value > max_size)
			return max_size;
		return value;
	endfunction

	function automatic int active_rows();
		return clamp_grid_size(int'(rows_reg), GRID_ROWS);
	endfunction

	function automatic int active_cols();
		return clamp_grid_size(int'(cols_reg), GRID_COLS);
	endfunction

	// One B3/S23 generation over the active region; cells outside it stay put.
	function automatic void advance_life_grid();
		bit [GRID_COLS-1:0] next_cells [GRID_ROWS];
		int nr, nc, up, dn, lf, rt, live;
		nr = active_rows();
		nc = active_cols();
		next_cells = life_grid;
		for (int r = 0; r < nr; r++) begin
			up = (r + nr - 1) % nr;
			dn = (r + 1) % nr;
			for (int c = 0; c < nc; c++) begin
				lf = (c + nc - 1) % nc;
				rt = (c + 1) % nc;
				live = life_grid[up][lf] + life_grid[up][c] + life_grid[up][rt]
					+ life_grid[r][lf] + life_grid[r][rt]
					+ life_grid[dn][lf] + life_grid[dn][c] + life_grid[dn][rt];
				next_cells[r][c] = (live == LIVE_BIRTH) ||
					(live == LIVE_KEEP && life_grid[r][c]);
			end
		end
		life_grid = next_cells;
	endfunction

	// Apply one accepted item to the predictor and queue its expected result.
	function automatic void predict_item(opcode_t op, logic [ROW_IDX_W-1:0] row,
			logic [COL_IDX_W-1:0] col, logic val);
		logic cell_val;
		cell_val = 1'b0;
		case (op)
			OP_WRITE: life_grid[row][col] = val;
			OP_STEP:  advance_life_grid();
			OP_READ:  cell_val = life_grid[row][col];
			default:  ;
		endcase
		expected_cell_out.push_back(cell_val);
		expected_done_op.push_back(op);
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED_ERRORS)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Offer one item, after a random gap while sender idling is on, and wait for its transaction.
	task automatic send_item(opcode_t op, logic [ROW_IDX_W-1:0] row,
			logic [COL_IDX_W-1:0] col, logic val);
		int gap;
		gap = sender_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= op;
		req_ch.row_index <= row;
		req_ch.col_index <= col;
		req_ch.cell_in   <= val;
		do @(posedge clk); while (!req_ch.ready);
		predict_item(op, row, col, val);
		items_sent++;
		op_count[op]++;
	endtask

	// Stop offering items and wait until every expected result has arrived.
	task automatic wait_for_idle();
		req_ch.valid <= 1'b0;
		while (expected_done_op.size() != 0)
			@(posedge clk);
	endtask

	// Write one configuration register while the block is idle.
	task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
		wait_for_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_ROWS)
			rows_reg = value[ROWS_REG_W-1:0];
		else
			cols_reg = value[COLS_REG_W-1:0];
		settings_written++;
		@(posedge clk);
	endtask

	// Both registers, in random order.
	task automatic set_grid_size(logic [CFG_DATA_W-1:0] rows_value,
			logic [CFG_DATA_W-1:0] cols_value);
		if ($urandom_range(0, 1)) begin
			write_register(CFG_ROWS, rows_value);
			write_register(CFG_COLS, cols_value);
		end else begin
			write_register(CFG_COLS, cols_value);
			write_register(CFG_ROWS, rows_value);
		end
	endtask

	// Reads right after reset see a dead grid; the unused opcode is echoed.
	task automatic test_reset_state();
		send_item(OP_READ, 5'd0, 7'd0, 1'b1);
		send_item(OP_READ, 5'd31, 7'd127, 1'b0);
		send_item(OP_READ, 5'd24, 7'd79, 1'b1);
		send_item(OP_UNUSED, 5'd31, 7'd127, 1'b1);
		send_item(OP_UNUSED, 5'd0, 7'd0, 1'b0);
		send_item(OP_READ, 5'd0, 7'd0, 1'b0);
	endtask

	// Corner cells of the storage, inside and outside the active region.
	task automatic test_cell_extremes();
		send_item(OP_WRITE, 5'd0, 7'd0, 1'b1);
		send_item(OP_WRITE, 5'd31, 7'd127, 1'b1);
		send_item(OP_WRITE, 5'd0, 7'd127, 1'b1);
		send_item(OP_WRITE, 5'd31, 7'd0, 1'b1);
		send_item(OP_READ, 5'd0, 7'd0, 1'b0);
		send_item(OP_READ, 5'd31, 7'd127, 1'b0);
		send_item(OP_READ, 5'd0, 7'd127, 1'b0);
		send_item(OP_READ, 5'd31, 7'd0, 1'b0);
		send_item(OP_WRITE, 5'd31, 7'd127, 1'b0);
		send_item(OP_READ, 5'd31, 7'd127, 1'b1);
	endtask

	// A blinker that straddles the vertical wrap; a cell outside the region
	// must survive the step untouched.
	task automatic test_wrap_blinker();
		send_item(OP_WRITE, 5'd24, 7'd79, 1'b1);
		send_item(OP_WRITE, 5'd0, 7'd79, 1'b1);
		send_item(OP_WRITE, 5'd1, 7'd79, 1'b1);
		send_item(OP_WRITE, 5'd30, 7'd100, 1'b1);
		send_item(OP_STEP, 5'd31, 7'd127, 1'b1);
		send_item(OP_READ, 5'd0, 7'd78, 1'b0);
		send_item(OP_READ, 5'd0, 7'd79, 1'b0);
		send_item(OP_READ, 5'd0, 7'd0, 1'b0);
		send_item(OP_READ, 5'd24, 7'd79, 1'b0);
		send_item(OP_READ, 5'd30, 7'd100, 1'b0);
	endtask

	// Size registers below the minimum and above the storage are clamped.
	task automatic test_size_clamp();
		set_grid_size(8'd0, 8'd0);
		send_item(OP_WRITE, 5'd1, 7'd0, 1'b1);
		send_item(OP_WRITE, 5'd1, 7'd2, 1'b1);
		send_item(OP_STEP, 5'd0, 7'd0, 1'b0);
		send_item(OP_READ, 5'd0, 7'd0, 1'b0);
		send_item(OP_READ, 5'd1, 7'd1, 1'b0);
		set_grid_size(8'hFF, 8'hFF);
		send_item(OP_STEP, 5'd0, 7'd0, 1'b0);
		send_item(OP_READ, 5'd31, 7'd127, 1'b0);
	endtask

	// Clear a window, launch a glider, run a few generations, read the window.
	task automatic test_glider_flight();
		int nr, nc, r0, c0, steps;
		int rv [4];
		int cv [4];
		rv = '{3, 6, 32, 12};
		cv = '{3, 7, 128, 40};
		for (int s = 0; s < 4; s++) begin
			set_grid_size(CFG_DATA_W'(rv[s]), CFG_DATA_W'(cv[s]));
			sender_idle_on = (s != 2);
			receiver_idle_on = (s != 1);
			nr = active_rows();
			nc = active_cols();
			r0 = $urandom_range(0, nr - 1);
			c0 = $urandom_range(0, nc - 1);
			for (int dr = 0; dr < 5; dr++)
				for (int dc = 0; dc < 5; dc++)
					send_item(OP_WRITE, ROW_IDX_W'((r0 + dr) % nr),
						COL_IDX_W'((c0 + dc) % nc), 1'b0);
			send_item(OP_WRITE, ROW_IDX_W'(r0 % nr), COL_IDX_W'((c0 + 1) % nc), 1'b1);
			send_item(OP_WRITE, ROW_IDX_W'((r0 + 1) % nr), COL_IDX_W'((c0 + 2) % nc), 1'b1);
			send_item(OP_WRITE, ROW_IDX_W'((r0 + 2) % nr), COL_IDX_W'(c0 % nc), 1'b1);
			send_item(OP_WRITE, ROW_IDX_W'((r0 + 2) % nr), COL_IDX_W'((c0 + 1) % nc), 1'b1);
			send_item(OP_WRITE, ROW_IDX_W'((r0 + 2) % nr), COL_IDX_W'((c0 + 2) % nc), 1'b1);
			steps = $urandom_range(1, 4);
			for (int k = 0; k < steps; k++)
				send_item(OP_STEP, ROW_IDX_W'($urandom_range(0, 31)),
					COL_IDX_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
			for (int dr = 0; dr < 5; dr++)
				for (int dc = 0; dc < 5; dc++)
					send_item(OP_READ, ROW_IDX_W'((r0 + dr) % nr),
						COL_IDX_W'((c0 + dc) % nc), 1'($urandom_range(0, 1)));
		end
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
	endtask

	// Random soups under several sizes: mostly region writes, reads and steps,
	// with some traffic outside the region and the unused opcode as noise.
	task automatic test_random_soup(int items_per_phase);
		logic [CFG_DATA_W-1:0] rows_value, cols_value;
		int nr, nc, sel;
		logic [ROW_IDX_W-1:0] row;
		logic [COL_IDX_W-1:0] col;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin rows_value = 8'd3;  cols_value = 8'd3;   end
				1: begin rows_value = 8'd32; cols_value = 8'd128; end
				2: begin rows_value = 8'd1;  cols_value = 8'd255; end
				3: begin rows_value = 8'hFF; cols_value = 8'd2;   end
				default: begin
					rows_value = CFG_DATA_W'($urandom_range(0, 255));
					cols_value = CFG_DATA_W'($urandom_range(0, 255));
				end
			endcase
			set_grid_size(rows_value, cols_value);
			nr = active_rows();
			nc = active_cols();
			for (int i = 0; i < items_per_phase; i++) begin
				// Idle-free stretches on either side now and then.
				if (i % 40 == 0) begin
					sender_idle_on = ($urandom_range(0, 2) != 0);
					receiver_idle_on = ($urandom_range(0, 2) != 0);
				end
				if ($urandom_range(0, 99) < 85) begin
					row = ROW_IDX_W'($urandom_range(0, nr - 1));
					col = COL_IDX_W'($urandom_range(0, nc - 1));
				end else begin
					row = ROW_IDX_W'($urandom_range(0, 31));
					col = COL_IDX_W'($urandom_range(0, 127));
				end
				sel = $urandom_range(0, 99);
				if (sel < 45)
					send_item(OP_WRITE, row, col, 1'($urandom_range(0, 1)));
				else if (sel < 80)
					send_item(OP_READ, row, col, 1'($urandom_range(0, 1)));
				else if (sel < 95)
					send_item(OP_STEP, row, col, 1'($urandom_range(0, 1)));
				else
					send_item(OP_UNUSED, row, col, 1'($urandom_range(0, 1)));
			end
		end
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
	endtask

	// The receiver holds off while items keep coming back to back.
	task automatic test_backpressure();
		int sel;
		wait_for_idle();
		sender_idle_on = 1'b0;
		receiver_idle_on = 1'b0;
		hold_cycles = HOLD_OFF_CYCLES;
		for (int i = 0; i < 40; i++) begin
			sel = $urandom_range(0, 2);
			if (sel == 0)
				send_item(OP_WRITE, ROW_IDX_W'($urandom_range(0, 31)),
					COL_IDX_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
			else if (sel == 1)
				send_item(OP_READ, ROW_IDX_W'($urandom_range(0, 31)),
					COL_IDX_W'($urandom_range(0, 127)), 1'b0);
			else
				send_item(OP_STEP, 5'd0, 7'd0, 1'b0);
		end
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
	endtask

	// Receiver: random stall after each transaction while receiver idling is on, plus the long hold-off.
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				stall = receiver_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		logic    want_cell;
		opcode_t want_op;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_done_op.size() == 0) begin
				report_mismatch($sformatf(
					"result with no item pending: cell_out %0b done_opcode %0d",
					rsp_ch.cell_out, rsp_ch.done_opcode));
			end else begin
				want_cell = expected_cell_out.pop_front();
				want_op = expected_done_op.pop_front();
				results_checked++;
				if (rsp_ch.done_opcode !== want_op)
					report_mismatch($sformatf("result %0d: done_opcode %0d, expected %0d",
						results_checked, rsp_ch.done_opcode, want_op));
				if (rsp_ch.cell_out !== want_cell)
					report_mismatch($sformatf("result %0d: cell_out %0b, expected %0b",
						results_checked, rsp_ch.cell_out, want_cell));
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.",
			cycle_count, expected_done_op.size());
		$display("toroidal_life_generation_engine_core test failed");
		$finish;
	end

	// Test sequence.
	initial begin
		req_ch.valid     = 1'b0;
		req_ch.opcode    = OP_WRITE;
		req_ch.row_index = '0;
		req_ch.col_index = '0;
		req_ch.cell_in   = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = CFG_ROWS;
		cfg_ch.data      = '0;
		arst_n           = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_cell_extremes();
		test_wrap_blinker();
		test_size_clamp();
		test_glider_flight();
		test_random_soup(110);
		test_backpressure();

		wait_for_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items: %0d writes, %0d steps, %0d reads, %0d unused opcodes.",
			items_sent, op_count[OP_WRITE], op_count[OP_STEP], op_count[OP_READ],
			op_count[OP_UNUSED]);
		$display("Checked %0d results over %0d register writes, with one long hold-off.",
			results_checked, settings_written);
		if (error_count == 0)
			$display("toroidal_life_generation_engine_core test passed");
		else
			$display("toroidal_life_generation_engine_core test failed");
		$finish;
	end

endmodule
